### rtl/ffd_pkg.sv
// Shared types and constants for the first-fit task dispatcher.
// No dependencies; every other file in rtl imports this package.
package ffd_pkg;

    // Sizing of the task queue and the agent pool.
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_AGENTS  = 16;

    // Index and count widths that follow from the queue depth.
    localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    // Command kinds; the remaining code is ignored.
    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_OFFER  = 2'd2
    } kind_t;

    // One command transfer.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] task_handle;
        logic        pool_wide;
        logic [15:0] eligible_mask;
        logic [3:0]  agent_index;
        logic        turn_ready;
        logic        attached;
        logic        blocking;
        logic        mail_waiting;
        logic        in_flight;
    } cmd_t;

    // One assignment result.
    typedef struct packed {
        logic [3:0]  assigned_agent;
        logic [3:0]  task_slot;
        logic [15:0] assigned_handle;
    } result_t;

    // Task contents held by one queue slot.
    typedef struct packed {
        logic [15:0] handle;
        logic        pool_wide;
        logic [15:0] mask;
    } slot_t;

    // Search token that walks the cell chain, one cell per cycle.
    typedef struct packed {
        logic        active;
        logic        found;
        logic [3:0]  agent;
        logic [3:0]  slot;
        logic [15:0] handle;
    } probe_t;

endpackage

### rtl/ffd_cell.sv
// One queue slot of the dispatcher chain: holds a task and its claim mark.
// Depends on ffd_pkg for the slot and probe types.
module ffd_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [ffd_pkg::SLOT_W-1:0] slot_idx,
    input  logic                       clear,
    input  logic                       wr_en,
    input  ffd_pkg::slot_t             wr_data,
    input  ffd_pkg::probe_t            probe_in,
    output ffd_pkg::probe_t            probe_out
);
    import ffd_pkg::*;

    slot_t  slot_reg;
    logic   valid_reg;
    logic   valid_next;
    logic   claimed_reg;
    logic   claimed_next;
    probe_t probe_reg;
    probe_t probe_next;
    logic   allows;
    logic   hit;

    // The task accepts the agent if it is pool-wide or the agent's mask bit is set.
    assign allows = slot_reg.pool_wide | slot_reg.mask[probe_in.agent];
    assign hit    = probe_in.active & ~probe_in.found & valid_reg & ~claimed_reg & allows;

    // Claim on the first fit, otherwise pass the token on unchanged.
    always_comb
    begin
        probe_next   = probe_in;
        valid_next   = valid_reg;
        claimed_next = claimed_reg;
        if (clear)
        begin
            valid_next   = 1'b0;
            claimed_next = 1'b0;
        end
        else if (wr_en)
        begin
            valid_next   = 1'b1;
            claimed_next = 1'b0;
        end
        else if (hit)
        begin
            claimed_next     = 1'b1;
            probe_next.found = 1'b1;
            probe_next.slot  = 4'(slot_idx);
            probe_next.handle = slot_reg.handle;
        end
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            claimed_reg <= 1'b0;
            probe_reg   <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            claimed_reg <= claimed_next;
            probe_reg   <= probe_next;
        end
    end

    // Task payload, written on append only.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg <= wr_data;
        end
    end

    assign probe_out = probe_reg;

endmodule

### rtl/first_fit_task_dispatcher.sv
// Top level of the first-fit task dispatcher: command decode, queue count
// and the chain of ffd_cell slots. Depends on ffd_pkg and ffd_cell.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+---------------------
//  command   | start in, busy out      | cmd (ffd_pkg::cmd_t)
//  result    | result_valid out        | result (ffd_pkg::result_t)
//
// Clear and append commands never raise busy.
// A ready agent offer sends a token down the chain of QUEUE_DEPTH cells, one cell
// per cycle; the result (or nothing) is transferred as the token leaves the last
// cell, and busy stays high until the token has left, so a new offer cannot be
// taken before the last one is through.
// Reset empties the queue and clears all claim marks; task payloads are not reset.
// The result is shown for one cycle only and the receiver cannot stall it.
module first_fit_task_dispatcher (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ffd_pkg::cmd_t    cmd,
    output logic             result_valid,
    output ffd_pkg::result_t result
);
    import ffd_pkg::*;

    logic                   accept;
    logic                   agent_ok;
    logic                   do_clear;
    logic                   do_append;
    logic                   do_offer;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   busy_reg;
    logic                   busy_next;
    slot_t                  wr_data;
    probe_t                 chain [0:QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] wr_en;
    logic [QUEUE_DEPTH-1:0] probe_active;

    // Command decode.
    assign accept    = start & ~busy_reg;
    assign agent_ok  = (32'(cmd.agent_index) < MAX_AGENTS) & cmd.turn_ready & ~cmd.attached
                     & ~cmd.blocking & ~cmd.mail_waiting & ~cmd.in_flight;
    assign do_clear  = accept & (cmd.kind == KIND_CLEAR);
    assign do_append = accept & (cmd.kind == KIND_APPEND) & (32'(count_reg) < QUEUE_DEPTH);
    assign do_offer  = accept & (cmd.kind == KIND_OFFER) & agent_ok;

    assign wr_data.handle    = cmd.task_handle;
    assign wr_data.pool_wide = cmd.pool_wide;
    assign wr_data.mask      = cmd.eligible_mask;

    // Token launched into the first cell on an offer transfer.
    always_comb
    begin
        chain[0]        = '0;
        chain[0].active = do_offer;
        chain[0].agent  = cmd.agent_index;
    end

    // Queue count and busy flag.
    always_comb
    begin
        count_next = count_reg;
        if (do_clear)
        begin
            count_next = '0;
        end
        else if (do_append)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        busy_next = busy_reg ? ~chain[QUEUE_DEPTH].active : do_offer;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
        end
    end

    // Row of slot cells; the token passes from each cell to the next.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        assign wr_en[i]        = do_append & (count_reg == CNT_W'(i));
        assign probe_active[i] = chain[i+1].active;

        ffd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .slot_idx  (SLOT_W'(i)),
            .clear     (do_clear),
            .wr_en     (wr_en[i]),
            .wr_data   (wr_data),
            .probe_in  (chain[i]),
            .probe_out (chain[i+1])
        );
    end

    // Result from the token leaving the last cell.
    assign busy                   = busy_reg;
    assign result_valid           = chain[QUEUE_DEPTH].active & chain[QUEUE_DEPTH].found;
    assign result.assigned_agent  = chain[QUEUE_DEPTH].agent;
    assign result.task_slot       = chain[QUEUE_DEPTH].slot;
    assign result.assigned_handle = chain[QUEUE_DEPTH].handle;

    // A result only appears while an offer is being searched.
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy_reg)
        else $error("result without an offer in progress");

    // At most one token travels the chain.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(probe_active))
        else $error("more than one search token in the chain");

    // The queue never holds more tasks than it has slots.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= QUEUE_DEPTH)
        else $error("queue count beyond depth");

    // A ready offer makes the block busy in the next cycle.
    a_offer_busy: assert property (@(posedge clk) disable iff (!rst_n)
        do_offer |=> busy_reg)
        else $error("offer transfer did not start a search");

endmodule
